FILE: hw/rtl/hcss_pkg.sv
// ----------------------------------------------------------------------------
// hcss_pkg
// shared constants, types and helper function of the candidate scatter sorter
// ----------------------------------------------------------------------------
package hcss_pkg;

  localparam int CAND_N  = 64;
  localparam int ID_W    = 6;
  localparam int GRID_W  = 8;
  localparam int CELL_W  = 3;
  localparam int DIVS_W  = 10;

  localparam logic [31:0] MIX_C1 = 32'h7feb352d;
  localparam logic [31:0] MIX_C2 = 32'h846ca68b;
  localparam logic [31:0] ID_MUL = 32'h9e3779b9;
  localparam logic [31:0] ST_MUL = 32'h85ebca6b;

  localparam logic [3:0] STREAM_KEY = 4'd4;

  typedef struct packed {
    logic            go;
    logic [ID_W-1:0] id;
    logic [3:0]      stream;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hash;
  } hash_rsp_t;

  typedef struct packed {
    logic              go;
    logic [31:0]       dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [31:0]       quot;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] stream_salt(input logic [3:0] s);
    logic [35:0] p;
    p = {32'd0, s} * {4'd0, ST_MUL};
    return p[31:0];
  endfunction

endpackage

FILE: hw/rtl/hashed_candidate_scatter_sorter_top.sv
// ----------------------------------------------------------------------------
// hashed_candidate_scatter_sorter_top
// hashed grid candidate generator with key sort and ordered emission
// ----------------------------------------------------------------------------
// a transaction on the input channel (start high while busy is low) with
// in_generate_req set starts one run; with it clear, or with an invalid
// material range, nothing happens and busy stays low
// a run hashes the sort key of all 64 candidates into a key ram, ranks each
// candidate by sweeping the key ram once per candidate (bound by the single
// ram read port), then emits the candidates in sorted order, each needing
// 11 hashes on the shared hash unit, 6 reciprocal scalings and 2 serial
// remainders; busy is high throughout, so the next transaction waits for
// the end of the run
// each result sits on the out_ ports for one cycle with out_valid high and
// cannot be held off; out_last marks the 64th result, with which busy drops
// registers are written over the apb port while idle, a rule for the user
// that the block does not enforce; pready is tied high; synchronous reset
// returns to idle and loads register defaults
// ----------------------------------------------------------------------------
module hashed_candidate_scatter_sorter_top
  import hcss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_generate_req,
  output logic        out_valid,
  output logic [5:0]  out_cand_id,
  output logic [15:0] out_anchor_x,
  output logic [15:0] out_anchor_y,
  output logic [15:0] out_anchor_z,
  output logic [23:0] out_phase_turn,
  output logic [23:0] out_kind_rank,
  output logic [15:0] out_travel_amp,
  output logic [16:0] out_motion_speed,
  output logic [16:0] out_flutter_amt,
  output logic [31:0] out_rand_word,
  output logic [15:0] out_material_pair,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] REG_SEED  = 3'd0;
  localparam logic [2:0] REG_LBASE = 3'd1;
  localparam logic [2:0] REG_LCNT  = 3'd2;
  localparam logic [2:0] REG_MBASE = 3'd3;
  localparam logic [2:0] REG_MCNT  = 3'd4;

  localparam logic [3:0] F_AX = 4'd0;
  localparam logic [3:0] F_AZ = 4'd1;
  localparam logic [3:0] F_AY = 4'd2;
  localparam logic [3:0] F_PH = 4'd3;
  localparam logic [3:0] F_KR = 4'd4;
  localparam logic [3:0] F_TA = 4'd5;
  localparam logic [3:0] F_MS = 4'd6;
  localparam logic [3:0] F_FA = 4'd7;
  localparam logic [3:0] F_RW = 4'd8;
  localparam logic [3:0] F_LM = 4'd9;
  localparam logic [3:0] F_MM = 4'd10;

  localparam logic [ID_W-1:0] ID_LAST = ID_W'(CAND_N - 1);

  // reciprocal of 25 scaled by 2^26, exact for operands below 2^21
  localparam logic [21:0] RECIP_25 = 22'd2684355;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL_GO, S_FILL_WAIT, S_RK_RD, S_RK_KEY, S_RK_SWEEP, S_RK_WR,
    S_EM_RD, S_EM_ID, S_EM_HGO, S_EM_HW, S_EM_DW, S_EM_RC, S_EM_NEXT, S_EM_OUT
  } state_t;

  state_t state_r;

  logic [31:0] seed_r;
  logic [7:0]  lbase_r;
  logic [8:0]  lcnt_r;
  logic [7:0]  mbase_r;
  logic [8:0]  mcnt_r;

  logic [ID_W-1:0] i_r;
  logic [ID_W:0]   j_r;
  logic [ID_W-1:0] jd_r;
  logic            cv_r;
  logic [ID_W-1:0] rank_r;
  logic [23:0]     ki_r;
  logic [ID_W-1:0] k_r;
  logic [ID_W-1:0] id_r;
  logic [3:0]      f_r;
  logic [20:0]     rq_r;

  logic        valid_r;
  logic        last_r;
  logic [15:0] ax_r, ay_r, az_r, ta_r;
  logic [23:0] ph_r, kr_r;
  logic [16:0] ms_r, fa_r;
  logic [31:0] rw_r;
  logic [7:0]  lm_r, mm_r;

  hash_req_t hreq;
  hash_rsp_t hrsp;
  div_req_t  dreq;
  div_rsp_t  drsp;

  logic [23:0]     key_rdata;
  logic [ID_W-1:0] key_raddr;
  logic [ID_W-1:0] ord_rdata;
  logic            cfg_we;
  logic            range_ok;
  logic            less;
  logic            need_div;
  logic            use_div;
  logic            rc_anchor;
  logic [31:0]     rc_src;
  logic [20:0]     rc_q;
  logic [42:0]     rc_prod;
  logic [16:0]     rc_quot;
  logic [23:0]     u;
  logic [31:0]     u32;
  logic [31:0]     cell_x;
  logic [31:0]     cell_z;
  logic [9:0]      lsum, msum;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= 32'd0;
      lbase_r <= 8'd0;
      lcnt_r  <= 9'd1;
      mbase_r <= 8'd0;
      mcnt_r  <= 9'd1;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_SEED:  seed_r  <= pwdata;
        REG_LBASE: lbase_r <= pwdata[7:0];
        REG_LCNT:  lcnt_r  <= pwdata[8:0];
        REG_MBASE: mbase_r <= pwdata[7:0];
        REG_MCNT:  mcnt_r  <= pwdata[8:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SEED:  prdata = seed_r;
      REG_LBASE: prdata = {24'd0, lbase_r};
      REG_LCNT:  prdata = {23'd0, lcnt_r};
      REG_MBASE: prdata = {24'd0, mbase_r};
      REG_MCNT:  prdata = {23'd0, mcnt_r};
      default:   prdata = 32'd0;
    endcase
  end

  assign lsum     = {1'b0, lcnt_r} + {2'b0, lbase_r};
  assign msum     = {1'b0, mcnt_r} + {2'b0, mbase_r};
  assign range_ok = (lcnt_r != 9'd0) && (lsum <= 10'd256) &&
                    (mcnt_r != 9'd0) && (msum <= 10'd256);

  // ------------------------------------------------------------ shared units
  hcss_hash u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .seed (seed_r),
    .req  (hreq),
    .rsp  (hrsp)
  );

  hcss_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  hcss_ram #(.WIDTH(24), .DEPTH(CAND_N)) u_key_ram (
    .clk  (clk),
    .we   (state_r == S_FILL_WAIT && hrsp.done),
    .waddr(i_r),
    .wdata(hrsp.hash[31:8]),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  hcss_ram #(.WIDTH(ID_W), .DEPTH(CAND_N)) u_ord_ram (
    .clk  (clk),
    .we   (state_r == S_RK_WR),
    .waddr(rank_r),
    .wdata(i_r),
    .raddr(k_r),
    .rdata(ord_rdata)
  );

  assign key_raddr = (state_r == S_RK_RD) ? i_r : j_r[ID_W-1:0];
  assign less = (key_rdata < ki_r) || ((key_rdata == ki_r) && (jd_r < i_r));

  // hash requests
  always_comb begin
    hreq.go     = (state_r == S_FILL_GO) || (state_r == S_EM_HGO);
    hreq.id     = (state_r == S_FILL_GO) ? i_r : id_r;
    hreq.stream = STREAM_KEY;
    if (state_r != S_FILL_GO) begin
      case (f_r)
        F_AX:    hreq.stream = 4'd0;
        F_AZ:    hreq.stream = 4'd1;
        F_AY:    hreq.stream = 4'd2;
        F_PH:    hreq.stream = 4'd3;
        F_KR:    hreq.stream = 4'd5;
        F_TA:    hreq.stream = 4'd6;
        F_MS:    hreq.stream = 4'd7;
        F_FA:    hreq.stream = 4'd8;
        F_RW:    hreq.stream = 4'd9;
        F_LM:    hreq.stream = 4'd10;
        F_MM:    hreq.stream = 4'd11;
        default: hreq.stream = 4'd0;
      endcase
    end
  end

  // scaling operands pre-shifted by 256, divided by 800 or 100 as a shift
  // followed by a reciprocal multiply by 1/25
  assign u      = hrsp.hash[31:8];
  assign u32    = {8'd0, u};
  assign cell_x = {29'd0, id_r[CELL_W-1:0]};
  assign cell_z = {29'd0, id_r[ID_W-1:CELL_W]};

  always_comb begin
    need_div  = 1'b1;
    use_div   = 1'b0;
    rc_anchor = 1'b0;
    rc_src    = 32'd0;
    case (f_r)
      F_AX: begin
        rc_src    = cell_x * 32'd6553600 + 32'd983040 + ((u32 * 32'd70) >> 8);
        rc_anchor = 1'b1;
      end
      F_AZ: begin
        rc_src    = cell_z * 32'd6553600 + 32'd983040 + ((u32 * 32'd70) >> 8);
        rc_anchor = 1'b1;
      end
      F_AY:       rc_src  = 32'd655360 + ((u32 * 32'd80) >> 8);
      F_TA:       rc_src  = 32'd1835008 + ((u32 * 32'd52) >> 8);
      F_MS:       rc_src  = 32'd2752512 + ((u32 * 32'd76) >> 8);
      F_FA:       rc_src  = 32'd2949120 + ((u32 * 32'd55) >> 8);
      F_LM, F_MM: use_div = 1'b1;
      default:    need_div = 1'b0;
    endcase
    dreq.go       = (state_r == S_EM_HW) && hrsp.done && use_div;
    dreq.dividend = hrsp.hash;
    dreq.divisor  = (f_r == F_LM) ? {1'b0, lcnt_r} : {1'b0, mcnt_r};
  end

  assign rc_q    = rc_anchor ? rc_src[25:5] : rc_src[22:2];
  assign rc_prod = {22'd0, rq_r} * {21'd0, RECIP_25};
  assign rc_quot = rc_prod[42:26];

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      i_r     <= '0;
      k_r     <= '0;
      cv_r    <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && in_generate_req && range_ok) begin
            i_r     <= '0;
            state_r <= S_FILL_GO;
          end
        end
        S_FILL_GO: state_r <= S_FILL_WAIT;
        S_FILL_WAIT: begin
          if (hrsp.done) begin
            i_r     <= i_r + ID_W'(1);
            state_r <= (i_r == ID_LAST) ? S_RK_RD : S_FILL_GO;
          end
        end
        S_RK_RD: state_r <= S_RK_KEY;
        S_RK_KEY: begin
          ki_r    <= key_rdata;
          j_r     <= '0;
          rank_r  <= '0;
          cv_r    <= 1'b0;
          state_r <= S_RK_SWEEP;
        end
        S_RK_SWEEP: begin
          if (cv_r && less) begin
            rank_r <= rank_r + ID_W'(1);
          end
          if (j_r != (ID_W+1)'(CAND_N)) begin
            jd_r <= j_r[ID_W-1:0];
            j_r  <= j_r + (ID_W+1)'(1);
            cv_r <= 1'b1;
          end else begin
            cv_r    <= 1'b0;
            state_r <= S_RK_WR;
          end
        end
        S_RK_WR: begin
          i_r <= i_r + ID_W'(1);
          if (i_r == ID_LAST) begin
            k_r     <= '0;
            state_r <= S_EM_RD;
          end else begin
            state_r <= S_RK_RD;
          end
        end
        S_EM_RD: state_r <= S_EM_ID;
        S_EM_ID: begin
          id_r    <= ord_rdata;
          f_r     <= F_AX;
          state_r <= S_EM_HGO;
        end
        S_EM_HGO: state_r <= S_EM_HW;
        S_EM_HW: begin
          if (hrsp.done) begin
            if (use_div) begin
              state_r <= S_EM_DW;
            end else if (need_div) begin
              rq_r    <= rc_q;
              state_r <= S_EM_RC;
            end else begin
              case (f_r)
                F_PH:    ph_r <= u;
                F_KR:    kr_r <= u;
                default: rw_r <= hrsp.hash;
              endcase
              state_r <= S_EM_NEXT;
            end
          end
        end
        S_EM_RC: begin
          case (f_r)
            F_AX:    ax_r <= (rc_quot > 17'd65535) ? 16'hffff : rc_quot[15:0];
            F_AZ:    az_r <= (rc_quot > 17'd65535) ? 16'hffff : rc_quot[15:0];
            F_AY:    ay_r <= rc_quot[15:0];
            F_TA:    ta_r <= rc_quot[15:0];
            F_MS:    ms_r <= rc_quot;
            default: fa_r <= rc_quot;
          endcase
          state_r <= S_EM_NEXT;
        end
        S_EM_DW: begin
          if (drsp.done) begin
            case (f_r)
              F_LM:    lm_r <= lbase_r + drsp.rem[7:0];
              default: mm_r <= mbase_r + drsp.rem[7:0];
            endcase
            state_r <= S_EM_NEXT;
          end
        end
        S_EM_NEXT: begin
          if (f_r == F_MM) begin
            state_r <= S_EM_OUT;
          end else begin
            f_r     <= f_r + 4'd1;
            state_r <= S_EM_HGO;
          end
        end
        S_EM_OUT: begin
          valid_r <= 1'b1;
          last_r  <= (k_r == ID_LAST);
          k_r     <= k_r + ID_W'(1);
          state_r <= (k_r == ID_LAST) ? S_IDLE : S_EM_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = valid_r;
  assign out_cand_id       = id_r;
  assign out_anchor_x      = ax_r;
  assign out_anchor_y      = ay_r;
  assign out_anchor_z      = az_r;
  assign out_phase_turn    = ph_r;
  assign out_kind_rank     = kr_r;
  assign out_travel_amp    = ta_r;
  assign out_motion_speed  = ms_r;
  assign out_flutter_amt   = fa_r;
  assign out_rand_word     = rw_r;
  assign out_material_pair = {mm_r, lm_r};
  assign out_last          = last_r;

  // ------------------------------------------------------------ assertions
  a_idle_request_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_generate_req) |=> !busy)
    else $error("run started without a request");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy still high after the final result");

  a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("result strobe outside a run");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(hreq.go && dreq.go))
    else $error("hash and divider started together");

endmodule

FILE: hw/rtl/hcss_ram.sv
// ----------------------------------------------------------------------------
// hcss_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module hcss_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/hcss_hash.sv
// ----------------------------------------------------------------------------
// hcss_hash
// multi-cycle integer mix hash around one shared 32x32 multiplier
// ----------------------------------------------------------------------------
module hcss_hash
  import hcss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] seed,
  input  hash_req_t   req,
  output hash_rsp_t   rsp
);

  logic [2:0]  step_r;
  logic [31:0] acc_r;
  logic [3:0]  stream_r;
  logic        done_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] mixed;

  always_comb begin
    mul_a = acc_r;
    mul_b = MIX_C1;
    case (step_r)
      3'd0:    begin mul_a = {{(32-ID_W){1'b0}}, req.id}; mul_b = ID_MUL; end
      3'd2:    mul_b = MIX_C1;
      3'd4:    mul_b = MIX_C2;
      default: mul_b = MIX_C1;
    endcase
  end

  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
  assign mixed = seed ^ acc_r ^ stream_salt(stream_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (step_r)
        3'd0: begin
          if (req.go) begin
            acc_r    <= prod[31:0];
            stream_r <= req.stream;
            step_r   <= 3'd1;
          end
        end
        3'd1: begin acc_r <= mixed ^ (mixed >> 16); step_r <= 3'd2; end
        3'd2: begin acc_r <= prod[31:0];            step_r <= 3'd3; end
        3'd3: begin acc_r <= acc_r ^ (acc_r >> 15); step_r <= 3'd4; end
        3'd4: begin acc_r <= prod[31:0];            step_r <= 3'd5; end
        3'd5: begin
          acc_r  <= acc_r ^ (acc_r >> 16);
          done_r <= 1'b1;
          step_r <= 3'd0;
        end
        default: step_r <= 3'd0;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.hash = acc_r;

endmodule

FILE: hw/rtl/hcss_div.sv
// ----------------------------------------------------------------------------
// hcss_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hcss_div
  import hcss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic [5:0]        cnt_r;
  logic [31:0]       quot_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic              done_r;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, quot_r[31]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.go) begin
          busy_r <= 1'b1;
          cnt_r  <= 6'd0;
          quot_r <= req.dividend;
          rem_r  <= '0;
          dvs_r  <= req.divisor;
        end
      end else begin
        rem_r  <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        quot_r <= {quot_r[30:0], ge};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule
